// ===== rtl/psn_pkg.sv =====
// peak set normalizer: shared widths, result kind codes, job and queue types
// and the back-end state type
// no dependencies
`default_nettype none

package psn_pkg;

	localparam int MAX_PEAKS = 16;

	localparam int POS_W = 16;
	localparam int VAL_W = 16;
	localparam int OUT_W = 32;
	localparam int KIND_W = 2;
	localparam int FRAC_W = 16;

	localparam int CNT_W = $clog2(MAX_PEAKS + 1);
	localparam int IDX_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
	localparam int ADDR_W = IDX_W + 1;
	localparam int DEPTH = 2 ** ADDR_W;
	localparam int SUM_W = VAL_W + $clog2(MAX_PEAKS);
	localparam int DVD_W = POS_W + FRAC_W;
	localparam int STEP_W = $clog2(DVD_W);

	localparam logic [KIND_W-1:0] KIND_WIN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POS = 2'd1;
	localparam logic [KIND_W-1:0] KIND_VAL = 2'd2;

	typedef struct packed {
		logic [POS_W-1:0] win;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] n;
	} psn_job_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic wr_slot;
		logic rd_slot;
	} psn_qstat_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_WIN,
		B_RD,
		B_LDP,
		B_DVP,
		B_OUTP,
		B_LDV,
		B_DVV,
		B_OUTV
	} psn_bstate_t;

endpackage

`default_nettype wire

// ===== rtl/psn_front.sv =====
// peak set normalizer front end: accepts peak words, fills the two-bank
// position and magnitude stores, tracks sum and best peak, posts a job per set
// depends on psn_pkg
`default_nettype none

module psn_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [psn_pkg::POS_W-1:0]     peak_pos,
	input  wire logic [psn_pkg::VAL_W-1:0]     peak_val,
	input  wire logic                          last_peak,
	input  wire psn_pkg::psn_qstat_t           qstat,
	output logic                               push,
	output psn_pkg::psn_job_t                  push_job,
	input  wire logic [psn_pkg::ADDR_W-1:0]    rd_addr,
	output logic [psn_pkg::POS_W-1:0]          rd_pos,
	output logic [psn_pkg::VAL_W-1:0]          rd_val
);

	logic [psn_pkg::POS_W-1:0] pos_mem [psn_pkg::DEPTH];
	logic [psn_pkg::VAL_W-1:0] val_mem [psn_pkg::DEPTH];
	logic [psn_pkg::POS_W-1:0] rd_pos_q;
	logic [psn_pkg::VAL_W-1:0] rd_val_q;

	logic [psn_pkg::SUM_W-1:0] sum_q;
	logic [psn_pkg::VAL_W-1:0] best_val_q;
	logic [psn_pkg::POS_W-1:0] best_pos_q;
	logic [psn_pkg::CNT_W-1:0] cnt_q;

	logic                      take;
	logic                      room;
	logic                      better;
	logic [psn_pkg::SUM_W-1:0] sum_d;
	logic [psn_pkg::VAL_W-1:0] best_val_d;
	logic [psn_pkg::POS_W-1:0] best_pos_d;
	logic [psn_pkg::CNT_W-1:0] cnt_d;
	logic [psn_pkg::ADDR_W-1:0] wr_addr;

	assign in_stall = qstat.full;
	assign take = in_valid && !in_stall;
	assign room = cnt_q < psn_pkg::CNT_W'(psn_pkg::MAX_PEAKS);
	assign better = room && ((cnt_q == '0) || (peak_val > best_val_q));
	assign wr_addr = {qstat.wr_slot, cnt_q[psn_pkg::IDX_W-1:0]};

	always_comb begin
		sum_d = sum_q;
		cnt_d = cnt_q;
		if (room) begin
			sum_d = sum_q + psn_pkg::SUM_W'(peak_val);
			cnt_d = cnt_q + psn_pkg::CNT_W'(1);
		end
		best_val_d = better ? peak_val : best_val_q;
		best_pos_d = better ? peak_pos : best_pos_q;
	end

	always_comb begin
		push = take && last_peak;
		push_job.win = (best_pos_d == '0) ? psn_pkg::POS_W'(1) : best_pos_d;
		push_job.sum = (sum_d == '0) ? psn_pkg::SUM_W'(1) : sum_d;
		push_job.n = cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			best_val_q <= '0;
			best_pos_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (last_peak) begin
				sum_q <= '0;
				best_val_q <= '0;
				best_pos_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_d;
				best_val_q <= best_val_d;
				best_pos_q <= best_pos_d;
				cnt_q <= cnt_d;
			end
		end
	end

	// peak stores, one bank per queue slot
	always_ff @(posedge clk) begin
		if (take && room) begin
			pos_mem[wr_addr] <= peak_pos;
			val_mem[wr_addr] <= peak_val;
		end
		rd_pos_q <= pos_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	assign rd_pos = rd_pos_q;
	assign rd_val = rd_val_q;

endmodule

`default_nettype wire

// ===== rtl/psn_jobq.sv =====
// peak set normalizer job queue: two set descriptors between front and back,
// slot pointers double as store bank selects
// depends on psn_pkg
`default_nettype none

module psn_jobq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire psn_pkg::psn_job_t    push_job,
	input  wire logic                 pop,
	output psn_pkg::psn_job_t         head,
	output psn_pkg::psn_qstat_t       qstat
);

	psn_pkg::psn_job_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

	assign head = slot_q[rd_ptr_q];

	always_comb begin
		qstat.full = cnt_q == 2'd2;
		qstat.empty = cnt_q == 2'd0;
		qstat.wr_slot = wr_ptr_q;
		qstat.rd_slot = rd_ptr_q;
	end

endmodule

`default_nettype wire

// ===== rtl/psn_div.sv =====
// peak set normalizer serial divider: restoring, one quotient bit per cycle
// depends on psn_pkg
`default_nettype none

module psn_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [psn_pkg::DVD_W-1:0]     dvd,
	input  wire logic [psn_pkg::SUM_W-1:0]     dvs,
	output logic [psn_pkg::DVD_W-1:0]          quo,
	output logic                               done
);

	logic [psn_pkg::DVD_W-1:0]  dvd_q;
	logic [psn_pkg::SUM_W-1:0]  rem_q;
	logic [psn_pkg::SUM_W-1:0]  dvs_q;
	logic [psn_pkg::STEP_W-1:0] step_q;
	logic                       busy_q;
	logic                       done_q;

	logic [psn_pkg::SUM_W:0] trial;
	logic [psn_pkg::SUM_W:0] diff;
	logic                    ge;

	assign trial = {rem_q, dvd_q[psn_pkg::DVD_W-1]};
	assign ge = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + psn_pkg::STEP_W'(1);
				if (step_q == psn_pkg::STEP_W'(psn_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so it fits the divisor width
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dvd;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			rem_q <= ge ? diff[psn_pkg::SUM_W-1:0] : trial[psn_pkg::SUM_W-1:0];
			dvd_q <= {dvd_q[psn_pkg::DVD_W-2:0], ge};
		end
	end

	assign quo = dvd_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== rtl/psn_back.sv =====
// peak set normalizer back end: walks one stored set, runs both quotients per
// peak through the serial divider, holds the result word register
// depends on psn_pkg and psn_div
`default_nettype none

module psn_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire psn_pkg::psn_job_t             head,
	input  wire psn_pkg::psn_qstat_t           qstat,
	output logic                               pop,
	output logic [psn_pkg::ADDR_W-1:0]         rd_addr,
	input  wire logic [psn_pkg::POS_W-1:0]     rd_pos,
	input  wire logic [psn_pkg::VAL_W-1:0]     rd_val,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [psn_pkg::OUT_W-1:0]          out_value,
	output logic [psn_pkg::KIND_W-1:0]         out_kind,
	output logic                               out_last
);

	psn_pkg::psn_bstate_t state_q, state_d;
	logic [psn_pkg::CNT_W-1:0]  idx_q;
	logic                       out_valid_q;
	logic [psn_pkg::OUT_W-1:0]  out_value_q;
	logic [psn_pkg::KIND_W-1:0] out_kind_q;
	logic                       out_last_q;

	logic                       out_free;
	logic                       emit;
	logic [psn_pkg::OUT_W-1:0]  emit_value;
	logic [psn_pkg::KIND_W-1:0] emit_kind;
	logic                       emit_last;
	logic                       idx_clr;
	logic                       idx_inc;
	logic                       div_start;
	logic [psn_pkg::DVD_W-1:0]  div_dvd;
	logic [psn_pkg::SUM_W-1:0]  div_dvs;
	logic [psn_pkg::DVD_W-1:0]  div_quo;
	logic                       div_done;
	logic                       set_end;

	psn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.quo    (div_quo),
		.done   (div_done)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign rd_addr = {qstat.rd_slot, idx_q[psn_pkg::IDX_W-1:0]};
	assign set_end = (idx_q + psn_pkg::CNT_W'(1)) == head.n;

	always_comb begin
		state_d = state_q;
		emit = 1'b0;
		emit_value = div_quo;
		emit_kind = psn_pkg::KIND_POS;
		emit_last = 1'b0;
		idx_clr = 1'b0;
		idx_inc = 1'b0;
		div_start = 1'b0;
		div_dvd = {rd_pos, psn_pkg::FRAC_W'(0)};
		div_dvs = psn_pkg::SUM_W'(head.win);
		pop = 1'b0;
		unique case (state_q)
			psn_pkg::B_IDLE: begin
				if (!qstat.empty) begin
					idx_clr = 1'b1;
					state_d = psn_pkg::B_WIN;
				end
			end
			psn_pkg::B_WIN: begin
				if (out_free) begin
					emit = 1'b1;
					emit_value = {head.win, psn_pkg::FRAC_W'(0)};
					emit_kind = psn_pkg::KIND_WIN;
					emit_last = head.n == '0;
					if (head.n == '0) begin
						pop = 1'b1;
						state_d = psn_pkg::B_IDLE;
					end else begin
						state_d = psn_pkg::B_RD;
					end
				end
			end
			psn_pkg::B_RD: begin
				state_d = psn_pkg::B_LDP;
			end
			psn_pkg::B_LDP: begin
				div_start = 1'b1;
				state_d = psn_pkg::B_DVP;
			end
			psn_pkg::B_DVP: begin
				if (div_done)
					state_d = psn_pkg::B_OUTP;
			end
			psn_pkg::B_OUTP: begin
				if (out_free) begin
					emit = 1'b1;
					state_d = psn_pkg::B_LDV;
				end
			end
			psn_pkg::B_LDV: begin
				div_start = 1'b1;
				div_dvd = {rd_val, psn_pkg::FRAC_W'(0)};
				div_dvs = head.sum;
				state_d = psn_pkg::B_DVV;
			end
			psn_pkg::B_DVV: begin
				if (div_done)
					state_d = psn_pkg::B_OUTV;
			end
			psn_pkg::B_OUTV: begin
				if (out_free) begin
					emit = 1'b1;
					emit_kind = psn_pkg::KIND_VAL;
					emit_last = set_end;
					if (set_end) begin
						pop = 1'b1;
						state_d = psn_pkg::B_IDLE;
					end else begin
						idx_inc = 1'b1;
						state_d = psn_pkg::B_RD;
					end
				end
			end
			default: begin
				state_d = psn_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psn_pkg::B_IDLE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (idx_clr)
				idx_q <= '0;
			else if (idx_inc)
				idx_q <= idx_q + psn_pkg::CNT_W'(1);
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= emit_value;
			out_kind_q <= emit_kind;
			out_last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_kind = out_kind_q;
	assign out_last = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/peak_set_normalizer.sv =====
// peak set normalizer top level: front end, job queue and back end
// depends on psn_pkg, psn_front, psn_jobq, psn_back
//
//   port group   handshake             word
//   peak in      in_valid / in_stall   peak_pos, peak_val, last_peak
//   result out   out_valid / out_stall out_value, out_kind, out_last
//
// a peak word is taken while in_valid is high and in_stall is low; stores are two
// banks, one per queued set; each stored peak is read, then loaded, divided on the
// one serial divider and output once for its position and once for its magnitude
// a set adds the idle and winning position states; with the back end idle the
// winning position word passes the queue count, back-end state and result register
// in_stall is high while the queue holds two sets, the one in the back end included
// out_stall holds the result register; the back end waits at its next word
// reset clears counters, queue pointers and output valid; stores are not cleared
`default_nettype none

module peak_set_normalizer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [psn_pkg::POS_W-1:0]     peak_pos,
	input  wire logic [psn_pkg::VAL_W-1:0]     peak_val,
	input  wire logic                          last_peak,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [psn_pkg::OUT_W-1:0]          out_value,
	output logic [psn_pkg::KIND_W-1:0]         out_kind,
	output logic                               out_last
);

	psn_pkg::psn_qstat_t        qstat;
	psn_pkg::psn_job_t          push_job;
	psn_pkg::psn_job_t          head;
	logic                       push;
	logic                       pop;
	logic [psn_pkg::ADDR_W-1:0] rd_addr;
	logic [psn_pkg::POS_W-1:0]  rd_pos;
	logic [psn_pkg::VAL_W-1:0]  rd_val;

	psn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.peak_pos  (peak_pos),
		.peak_val  (peak_val),
		.last_peak (last_peak),
		.qstat     (qstat),
		.push      (push),
		.push_job  (push_job),
		.rd_addr   (rd_addr),
		.rd_pos    (rd_pos),
		.rd_val    (rd_val)
	);

	psn_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	psn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.rd_addr   (rd_addr),
		.rd_pos    (rd_pos),
		.rd_val    (rd_val),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_value (out_value),
		.out_kind  (out_kind),
		.out_last  (out_last)
	);

endmodule

`default_nettype wire

// ===== rtl/psn_checker.sv =====
// peak set normalizer port checker and its bind to the top level
// depends on psn_pkg and peak_set_normalizer
`default_nettype none

module psn_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [psn_pkg::OUT_W-1:0]     out_value,
	input  wire logic [psn_pkg::KIND_W-1:0]    out_kind,
	input  wire logic                          out_last
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value) &&
			$stable(out_kind) && $stable(out_last))
		else $error("result word changed while stalled");

	// winning position is a nonzero integer in q16.16
	a_win_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == psn_pkg::KIND_WIN |->
			out_value[15:0] == 16'd0 && out_value[31:16] != 16'd0)
		else $error("winning position word malformed");

	// a set always ends on a magnitude word
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_kind == psn_pkg::KIND_VAL)
		else $error("set ended on a word other than a magnitude");

	// a magnitude share never exceeds one
	a_val_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == psn_pkg::KIND_VAL |->
			out_value[31:16] == 16'd0 || out_value == 32'h0001_0000)
		else $error("normalized magnitude above one");

endmodule

bind peak_set_normalizer psn_checker u_psn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_value (out_value),
	.out_kind  (out_kind),
	.out_last  (out_last)
);

`default_nettype wire
